// ===== rtl/gpm_pkg.sv =====
`default_nettype none
package gpm_pkg;

	// Defaults for the top-level size parameters.
	localparam int unsigned MAX_VERTICES_DEF = 256;
	localparam int unsigned MAX_MODULES_DEF  = 256;

	// Field widths of the channels and the configuration port.
	localparam int unsigned OPC_W     = 2;
	localparam int unsigned VTX_W     = 8;
	localparam int unsigned MOD_W     = 9;
	localparam int unsigned CFG_W     = 9;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned Q_W       = 32;
	localparam int unsigned FRAC_W    = 30;

	// Counter widths; every counter saturates at its full range.
	localparam int unsigned DEG_W   = 8;
	localparam int unsigned EDGE_W  = 15;
	localparam int unsigned MEDGE_W = 15;
	localparam int unsigned MDEG_W  = 16;

	localparam logic [CFG_W-1:0] VC_RESET = 9'd256;
	localparam logic [CFG_W-1:0] MC_RESET = 9'd256;

	typedef enum logic [OPC_W-1:0] {
		OP_ADD_EDGE = 2'd0,
		OP_ASSIGN   = 2'd1,
		OP_COMPUTE  = 2'd2,
		OP_CLEAR    = 2'd3
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VERTEX_COUNT = 1'b0,
		CFG_MODULE_COUNT = 1'b1
	} cfg_reg_t;

	typedef enum logic [16:0] {
		S_CLR     = 17'h00001,
		S_IDLE    = 17'h00002,
		S_ADD_RD  = 17'h00004,
		S_ADD_CHK = 17'h00008,
		S_ADD_WB  = 17'h00010,
		S_MCLR    = 17'h00020,
		S_ROW     = 17'h00040,
		S_ROWD    = 17'h00080,
		S_PAIR    = 17'h00100,
		S_MRD     = 17'h00200,
		S_SUM     = 17'h00400,
		S_MUL     = 17'h00800,
		S_MAG     = 17'h01000,
		S_NUM     = 17'h02000,
		S_CHK     = 17'h04000,
		S_DIV     = 17'h08000,
		S_RES     = 17'h10000
	} state_t;

endpackage
`default_nettype wire

// ===== rtl/gpm_if.sv =====
`default_nettype none
// Input channel: one command transaction.
interface gpm_in_if;
	logic                        valid;
	logic                        ready;
	logic [gpm_pkg::OPC_W-1:0]   opcode;
	logic [gpm_pkg::VTX_W-1:0]   vertex_a;
	logic [gpm_pkg::VTX_W-1:0]   vertex_b;
	logic [gpm_pkg::MOD_W-1:0]   module_number;

	modport source(output valid, opcode, vertex_a, vertex_b, module_number, input ready);
	modport sink(input valid, opcode, vertex_a, vertex_b, module_number, output ready);
endinterface

// Output channel: one modularity result transaction.
interface gpm_out_if;
	logic                             valid;
	logic                             ready;
	logic signed [gpm_pkg::Q_W-1:0]   modularity;
	logic                             no_edges;

	modport source(output valid, modularity, no_edges, input ready);
	modport sink(input valid, modularity, no_edges, output ready);
endinterface
`default_nettype wire

// ===== rtl/gpm_ram.sv =====
`default_nettype none
// Single-port-write, single-port-read RAM with registered read data.
module gpm_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 256
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/graph_partition_modularity_unit.sv =====
`default_nettype none
// Newman modularity of a partitioned undirected graph.
// The item channel carries commands: add edge, assign a vertex to a module,
// compute, and clear. Only compute produces a transaction on the result
// channel: Q as signed fixed point with 30 fractional bits, or zero with
// no_edges set when the graph is empty. Configuration writes (vertex count,
// module count) are taken on any cycle through the plain write port.
// Assign writes the vertex-module memory as the item is accepted; add edge
// steps through a row read, a duplicate check and a degree write-back (one
// adjacency row and two degree read-modify-writes through the memories), and
// clear and reset run a clearing pass over all MAX_VERTICES rows during which
// no item is accepted. Compute clears the module sums one entry a cycle, tests
// each pair of an assigned vertex with a later vertex, one pair a cycle, against
// the vertex-module memory, reads the module sums back one a cycle, and a restoring
// divider produces one quotient bit a cycle. An empty graph skips to the result.
// The result sits in an output register; a stalled receiver holds it there and
// the block keeps accepting edge, assign and clear items meanwhile. A second
// compute waits for the register to be free before it delivers.
module graph_partition_modularity_unit #(
	parameter int unsigned MAX_VERTICES = gpm_pkg::MAX_VERTICES_DEF,
	parameter int unsigned MAX_MODULES  = gpm_pkg::MAX_MODULES_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [gpm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [gpm_pkg::CFG_W-1:0]       cfg_data,
	gpm_in_if.sink                               item,
	gpm_out_if.source                            result
);

	localparam int unsigned VW     = $clog2(MAX_VERTICES);
	localparam int unsigned VCW    = $clog2(MAX_VERTICES + 1);
	localparam int unsigned MAW    = MAX_MODULES > 1 ? $clog2(MAX_MODULES) : 1;
	localparam int unsigned MCW    = $clog2(MAX_MODULES + 1);
	localparam int unsigned EW     = gpm_pkg::EDGE_W;
	localparam int unsigned DW     = gpm_pkg::DEG_W;
	localparam int unsigned MEW    = gpm_pkg::MEDGE_W;
	localparam int unsigned MDW    = gpm_pkg::MDEG_W;
	localparam int unsigned QW     = gpm_pkg::Q_W;
	localparam int unsigned FW     = gpm_pkg::FRAC_W;
	localparam int unsigned ESUM_W = MEW + MCW;
	localparam int unsigned DSQ_W  = 2 * MDW + MCW;
	localparam int unsigned PRD_W  = EW + ESUM_W;
	localparam int unsigned POS_W  = PRD_W + 2;
	localparam int unsigned MAG_W  = POS_W > DSQ_W ? POS_W : DSQ_W;
	localparam int unsigned DEN_W  = 2 * EW + 2;
	localparam int unsigned NUM_W  = MAG_W + FW + 1;
	localparam int unsigned HI_W   = NUM_W - (QW - 1);
	localparam int unsigned CMP_W  = HI_W > DEN_W ? HI_W : DEN_W;
	localparam int unsigned MSW    = MEW + MDW;

	gpm_pkg::state_t state_q;

	// Configuration registers.
	logic [gpm_pkg::CFG_W-1:0] vc_q, mc_q;

	// Latched command fields.
	logic [VW-1:0] a_q, b_q, lo_q, hi_q;
	logic [EW-1:0] edge_q;

	// Compute walk.
	logic [VW-1:0]            clr_q;
	logic [VCW-1:0]           nv_q, i_q, j_q, j_s1, cnt_q;
	logic [MCW-1:0]           nm_q, k_q;
	logic [gpm_pkg::MOD_W-1:0] mi_q;
	logic [DW-1:0]            degi_q;
	logic [MAX_VERTICES-1:0]  row_q;
	logic                     pv_s1, sv_s1, sv_s2;
	logic [MEW-1:0]           e_s2;
	logic [2*MDW-1:0]         dd_s2;
	logic [ESUM_W-1:0]        esum_q;
	logic [DSQ_W-1:0]         dsq_q;
	logic [POS_W-1:0]         pos_q;
	logic [DEN_W-1:0]         den_q;
	logic [MAG_W-1:0]         mag_q;
	logic                     neg_q;
	logic [NUM_W-1:0]         num_q;
	logic [DEN_W-1:0]         rem_q;
	logic [QW-2:0]            low_q, qt_q;
	logic [4:0]               dc_q;
	logic [QW-1:0]            res_q;
	logic                     noedge_q;

	// Output register.
	logic                     out_valid_q;
	logic [QW-1:0]            out_q_q;
	logic                     out_ne_q;

	// Memory ports.
	logic                         adj_we, deg_we, vm_we, ms_we;
	logic [VW-1:0]                adj_wa, adj_ra, deg_wa, deg_ra, vm_wa, vm_ra;
	logic [MAW-1:0]               ms_wa, ms_ra;
	logic [MAX_VERTICES-1:0]      adj_wd, adj_rd;
	logic [DW-1:0]                deg_wd, deg_rd;
	logic [gpm_pkg::MOD_W-1:0]    vm_wd, vm_rd;
	logic [MSW-1:0]               ms_wd, ms_rd;

	gpm_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_wa), .wdata(adj_wd), .raddr(adj_ra), .rdata(adj_rd)
	);
	gpm_ram #(.WIDTH(DW), .DEPTH(MAX_VERTICES)) u_deg (
		.clk(clk), .we(deg_we), .waddr(deg_wa), .wdata(deg_wd), .raddr(deg_ra), .rdata(deg_rd)
	);
	gpm_ram #(.WIDTH(gpm_pkg::MOD_W), .DEPTH(MAX_VERTICES)) u_vmod (
		.clk(clk), .we(vm_we), .waddr(vm_wa), .wdata(vm_wd), .raddr(vm_ra), .rdata(vm_rd)
	);
	gpm_ram #(.WIDTH(MSW), .DEPTH(MAX_MODULES)) u_msum (
		.clk(clk), .we(ms_we), .waddr(ms_wa), .wdata(ms_wd), .raddr(ms_ra), .rdata(ms_rd)
	);

	// Handshake decode.
	logic            in_fire;
	gpm_pkg::opcode_t opc;
	logic            a_ok, b_ok, dup;

	assign item.ready = (state_q == gpm_pkg::S_IDLE);
	assign in_fire    = item.valid && item.ready;
	assign opc        = gpm_pkg::opcode_t'(item.opcode);
	assign a_ok       = 32'(item.vertex_a) < MAX_VERTICES;
	assign b_ok       = 32'(item.vertex_b) < MAX_VERTICES;
	assign dup        = adj_rd[hi_q];

	assign result.valid      = out_valid_q;
	assign result.modularity = out_q_q;
	assign result.no_edges   = out_ne_q;

	// Saturating counter updates, the products and the divider step.
	logic [DW-1:0]          deg_inc;
	logic [EW-1:0]          edge_inc;
	logic [MEW+VCW-1:0]     e_wide;
	logic [MDW:0]           d_wide;
	logic [MEW-1:0]         e_new;
	logic [MDW-1:0]         d_new;
	logic                   mi_ok, hit;
	logic [PRD_W-1:0]       me_prod;
	logic [2*EW-1:0]        mm_prod;
	logic [DEN_W:0]         div_t;
	logic                   qbit;
	logic [QW-2:0]          qt_next;

	always_comb begin
		deg_inc  = (deg_rd == '1) ? deg_rd : deg_rd + DW'(1);
		edge_inc = (edge_q == '1) ? edge_q : edge_q + EW'(1);
		e_wide   = (MEW+VCW)'(ms_rd[MSW-1:MDW]) + (MEW+VCW)'(cnt_q);
		e_new    = (e_wide > (MEW+VCW)'({MEW{1'b1}})) ? '1 : MEW'(e_wide);
		d_wide   = (MDW+1)'(ms_rd[MDW-1:0]) + (MDW+1)'(degi_q);
		d_new    = d_wide[MDW] ? '1 : d_wide[MDW-1:0];
		mi_ok    = (vm_rd != '0) && (32'(vm_rd) <= 32'(nm_q));
		hit      = pv_s1 && (vm_rd == mi_q) && row_q[j_s1[VW-1:0]];
		me_prod  = PRD_W'(edge_q) * PRD_W'(esum_q);
		mm_prod  = (2*EW)'(edge_q) * (2*EW)'(edge_q);
		div_t    = {rem_q, low_q[QW-2]};
		qbit     = div_t >= {1'b0, den_q};
		qt_next  = {qt_q[QW-3:0], qbit};
	end

	// Memory port control by state.
	always_comb begin
		adj_we = 1'b0;
		adj_wa = lo_q;
		adj_wd = adj_rd | (MAX_VERTICES'(1) << hi_q);
		adj_ra = lo_q;
		deg_we = 1'b0;
		deg_wa = a_q;
		deg_wd = deg_inc;
		deg_ra = a_q;
		vm_we  = 1'b0;
		vm_wa  = VW'(item.vertex_a);
		vm_wd  = item.module_number;
		vm_ra  = i_q[VW-1:0];
		ms_we  = 1'b0;
		ms_wa  = MAW'(mi_q - gpm_pkg::MOD_W'(1));
		ms_wd  = {e_new, d_new};
		ms_ra  = MAW'(mi_q - gpm_pkg::MOD_W'(1));
		case (state_q)
			gpm_pkg::S_CLR: begin
				adj_we = 1'b1;
				adj_wa = clr_q;
				adj_wd = '0;
				deg_we = 1'b1;
				deg_wa = clr_q;
				deg_wd = '0;
				vm_we  = 1'b1;
				vm_wa  = clr_q;
				vm_wd  = '0;
			end
			gpm_pkg::S_IDLE: begin
				vm_we = in_fire && (opc == gpm_pkg::OP_ASSIGN) && a_ok;
			end
			gpm_pkg::S_ADD_CHK: begin
				adj_we = !dup;
				deg_we = !dup;
				deg_ra = b_q;
			end
			gpm_pkg::S_ADD_WB: begin
				deg_we = 1'b1;
				deg_wa = b_q;
			end
			gpm_pkg::S_MCLR: begin
				ms_we = 1'b1;
				ms_wa = k_q[MAW-1:0];
				ms_wd = '0;
			end
			gpm_pkg::S_ROW: begin
				adj_ra = i_q[VW-1:0];
				deg_ra = i_q[VW-1:0];
			end
			gpm_pkg::S_PAIR: begin
				vm_ra = j_q[VW-1:0];
			end
			gpm_pkg::S_MRD: begin
				ms_we = 1'b1;
			end
			gpm_pkg::S_SUM: begin
				ms_ra = k_q[MAW-1:0];
			end
			default: begin
			end
		endcase
	end

	// Sequencer and datapath registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gpm_pkg::S_CLR;
			vc_q        <= gpm_pkg::VC_RESET;
			mc_q        <= gpm_pkg::MC_RESET;
			clr_q       <= '0;
			edge_q      <= '0;
			a_q         <= '0;
			b_q         <= '0;
			lo_q        <= '0;
			hi_q        <= '0;
			nv_q        <= '0;
			nm_q        <= '0;
			i_q         <= '0;
			j_q         <= '0;
			j_s1        <= '0;
			cnt_q       <= '0;
			k_q         <= '0;
			mi_q        <= '0;
			degi_q      <= '0;
			row_q       <= '0;
			pv_s1       <= 1'b0;
			sv_s1       <= 1'b0;
			sv_s2       <= 1'b0;
			e_s2        <= '0;
			dd_s2       <= '0;
			esum_q      <= '0;
			dsq_q       <= '0;
			pos_q       <= '0;
			den_q       <= '0;
			mag_q       <= '0;
			neg_q       <= 1'b0;
			num_q       <= '0;
			rem_q       <= '0;
			low_q       <= '0;
			qt_q        <= '0;
			dc_q        <= '0;
			res_q       <= '0;
			noedge_q    <= 1'b0;
			out_valid_q <= 1'b0;
			out_q_q     <= '0;
			out_ne_q    <= 1'b0;
		end else begin
			// Configuration writes are taken on any cycle.
			if (cfg_we) begin
				case (gpm_pkg::cfg_reg_t'(cfg_index))
					gpm_pkg::CFG_VERTEX_COUNT: vc_q <= cfg_data;
					gpm_pkg::CFG_MODULE_COUNT: mc_q <= cfg_data;
					default: begin
					end
				endcase
			end

			// The receiver drains the output register unless a new result lands in it.
			if (out_valid_q && result.ready && (state_q != gpm_pkg::S_RES)) begin
				out_valid_q <= 1'b0;
			end

			case (state_q)
				// Clearing pass over all vertex rows after reset or a clear item.
				gpm_pkg::S_CLR: begin
					clr_q <= clr_q + VW'(1);
					if (32'(clr_q) == MAX_VERTICES - 1) begin
						state_q <= gpm_pkg::S_IDLE;
					end
				end

				gpm_pkg::S_IDLE: begin
					if (in_fire) begin
						a_q  <= VW'(item.vertex_a);
						b_q  <= VW'(item.vertex_b);
						lo_q <= (item.vertex_a < item.vertex_b) ? VW'(item.vertex_a)
							: VW'(item.vertex_b);
						hi_q <= (item.vertex_a < item.vertex_b) ? VW'(item.vertex_b)
							: VW'(item.vertex_a);
						case (opc)
							gpm_pkg::OP_ADD_EDGE: begin
								if (a_ok && b_ok && (item.vertex_a != item.vertex_b)) begin
									state_q <= gpm_pkg::S_ADD_RD;
								end
							end
							gpm_pkg::OP_ASSIGN: begin
							end
							gpm_pkg::OP_COMPUTE: begin
								nv_q <= (32'(vc_q) > MAX_VERTICES) ? VCW'(MAX_VERTICES)
									: VCW'(vc_q);
								nm_q <= (32'(mc_q) > MAX_MODULES) ? MCW'(MAX_MODULES)
									: MCW'(mc_q);
								k_q  <= '0;
								if (edge_q == '0) begin
									res_q    <= '0;
									noedge_q <= 1'b1;
									state_q  <= gpm_pkg::S_RES;
								end else begin
									noedge_q <= 1'b0;
									state_q  <= gpm_pkg::S_MCLR;
								end
							end
							gpm_pkg::OP_CLEAR: begin
								clr_q   <= '0;
								edge_q  <= '0;
								state_q <= gpm_pkg::S_CLR;
							end
							default: begin
							end
						endcase
					end
				end

				// Edge insertion: row read, duplicate check, two degree updates unless a duplicate.
				gpm_pkg::S_ADD_RD: begin
					state_q <= gpm_pkg::S_ADD_CHK;
				end
				gpm_pkg::S_ADD_CHK: begin
					if (dup) begin
						state_q <= gpm_pkg::S_IDLE;
					end else begin
						edge_q  <= edge_inc;
						state_q <= gpm_pkg::S_ADD_WB;
					end
				end
				gpm_pkg::S_ADD_WB: begin
					state_q <= gpm_pkg::S_IDLE;
				end

				// Zero the per-module sums.
				gpm_pkg::S_MCLR: begin
					k_q <= k_q + MCW'(1);
					if (32'(k_q) == MAX_MODULES - 1) begin
						i_q     <= '0;
						state_q <= gpm_pkg::S_ROW;
					end
				end

				// Fetch row i: adjacency, degree and module.
				gpm_pkg::S_ROW: begin
					if (i_q < nv_q) begin
						state_q <= gpm_pkg::S_ROWD;
					end else begin
						k_q     <= '0;
						esum_q  <= '0;
						dsq_q   <= '0;
						sv_s1   <= 1'b0;
						sv_s2   <= 1'b0;
						state_q <= gpm_pkg::S_SUM;
					end
				end
				gpm_pkg::S_ROWD: begin
					mi_q   <= vm_rd;
					degi_q <= deg_rd;
					row_q  <= adj_rd;
					if (mi_ok) begin
						j_q     <= i_q + VCW'(1);
						cnt_q   <= '0;
						pv_s1   <= 1'b0;
						state_q <= gpm_pkg::S_PAIR;
					end else begin
						i_q     <= i_q + VCW'(1);
						state_q <= gpm_pkg::S_ROW;
					end
				end

				// One pair a cycle: read the module of j, test it in the cycle after.
				gpm_pkg::S_PAIR: begin
					if (hit) begin
						cnt_q <= cnt_q + VCW'(1);
					end
					if (j_q < nv_q) begin
						pv_s1 <= 1'b1;
						j_s1  <= j_q;
						j_q   <= j_q + VCW'(1);
					end else begin
						pv_s1 <= 1'b0;
						if (!pv_s1) begin
							state_q <= gpm_pkg::S_MRD;
						end
					end
				end

				// Fold the row's counts into its module entry.
				gpm_pkg::S_MRD: begin
					i_q     <= i_q + VCW'(1);
					state_q <= gpm_pkg::S_ROW;
				end

				// Sweep modules: edge sum and sum of squared degree sums.
				gpm_pkg::S_SUM: begin
					if (k_q < nm_q) begin
						sv_s1 <= 1'b1;
						k_q   <= k_q + MCW'(1);
					end else begin
						sv_s1 <= 1'b0;
					end
					sv_s2 <= sv_s1;
					e_s2  <= ms_rd[MSW-1:MDW];
					dd_s2 <= (2*MDW)'(ms_rd[MDW-1:0]) * (2*MDW)'(ms_rd[MDW-1:0]);
					if (sv_s2) begin
						esum_q <= esum_q + ESUM_W'(e_s2);
						dsq_q  <= dsq_q + DSQ_W'(dd_s2);
					end
					if (!(k_q < nm_q) && !sv_s1 && !sv_s2) begin
						state_q <= gpm_pkg::S_MUL;
					end
				end

				// Q = (4 m esum - dsq) / (4 m^2).
				gpm_pkg::S_MUL: begin
					pos_q   <= {me_prod, 2'b00};
					den_q   <= {mm_prod, 2'b00};
					state_q <= gpm_pkg::S_MAG;
				end
				gpm_pkg::S_MAG: begin
					neg_q   <= MAG_W'(dsq_q) > MAG_W'(pos_q);
					mag_q   <= (MAG_W'(dsq_q) > MAG_W'(pos_q)) ? MAG_W'(dsq_q) - MAG_W'(pos_q)
						: MAG_W'(pos_q) - MAG_W'(dsq_q);
					state_q <= gpm_pkg::S_NUM;
				end
				// Scale and add half the divisor for round-to-nearest.
				gpm_pkg::S_NUM: begin
					num_q   <= (NUM_W'(mag_q) << FW) + NUM_W'(den_q >> 1);
					state_q <= gpm_pkg::S_CHK;
				end
				// A quotient of 2^31 or more saturates.
				gpm_pkg::S_CHK: begin
					if (CMP_W'(num_q[NUM_W-1:QW-1]) >= CMP_W'(den_q)) begin
						res_q   <= neg_q ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
						state_q <= gpm_pkg::S_RES;
					end else begin
						rem_q   <= num_q[QW-1 +: DEN_W];
						low_q   <= num_q[QW-2:0];
						qt_q    <= '0;
						dc_q    <= '0;
						state_q <= gpm_pkg::S_DIV;
					end
				end
				// Restoring division, one quotient bit a cycle.
				gpm_pkg::S_DIV: begin
					rem_q <= qbit ? DEN_W'(div_t - {1'b0, den_q}) : DEN_W'(div_t);
					low_q <= {low_q[QW-3:0], 1'b0};
					qt_q  <= qt_next;
					dc_q  <= dc_q + 5'd1;
					if (32'(dc_q) == QW - 2) begin
						res_q   <= neg_q ? QW'(0) - {1'b0, qt_next} : {1'b0, qt_next};
						state_q <= gpm_pkg::S_RES;
					end
				end

				// Deliver once the output register is free.
				gpm_pkg::S_RES: begin
					if (!out_valid_q || result.ready) begin
						out_valid_q <= 1'b1;
						out_q_q     <= res_q;
						out_ne_q    <= noedge_q;
						state_q     <= gpm_pkg::S_IDLE;
					end
				end

				default: begin
					state_q <= gpm_pkg::S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none
module tb_top;
	import gpm_pkg::*;

	localparam int unsigned NV = MAX_VERTICES_DEF;
	localparam int unsigned NM = MAX_MODULES_DEF;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_data;

	gpm_in_if item_ch();
	gpm_out_if res_ch();

	graph_partition_modularity_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.item(item_ch),
		.result(res_ch)
	);

	// One expected modularity transaction.
	typedef struct {
		logic signed [Q_W-1:0] q;
		logic empty;
	} q_result_t;

	// Shadow copy of the graph, the partition and the registers.
	bit graph_adj[NV][NV];
	int unsigned deg[NV];
	int unsigned edge_cnt;
	int unsigned vtx_mod[NV];
	int unsigned vc_reg;
	int unsigned mc_reg;

	q_result_t q_pending[$];
	int unsigned err_count;
	int unsigned src_idle_pct;
	int unsigned snk_stall_pct;

	// Clock with a period of two time units.
	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic int unsigned sat_add(int unsigned v, int unsigned lim, int unsigned add);
		longint unsigned s;
		s = longint'(v) + add;
		return (s > lim) ? lim : int'(s);
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < NV; i++) begin
			deg[i] = 0;
			vtx_mod[i] = 0;
			for (int j = 0; j < NV; j++)
				graph_adj[i][j] = 1'b0;
		end
		edge_cnt = 0;
	endfunction

	// Modularity of the shadow graph, Q * 2^30 rounded and saturated.
	function automatic logic [Q_W-1:0] modularity_of_graph();
		int unsigned nv;
		int unsigned nm;
		int unsigned mi;
		int unsigned mod_edges[NM];
		int unsigned mod_deg[NM];
		longint unsigned m, esum, dsq, den, pos, mag, quo, rem, frac, val;
		bit neg;
		nv = (vc_reg > NV) ? NV : vc_reg;
		nm = (mc_reg > NM) ? NM : mc_reg;
		for (int i = 0; i < NM; i++) begin
			mod_edges[i] = 0;
			mod_deg[i] = 0;
		end
		for (int i = 0; i < nv; i++) begin
			mi = vtx_mod[i];
			if (mi == 0 || mi > nm)
				continue;
			mod_deg[mi-1] = sat_add(mod_deg[mi-1], 65535, deg[i]);
			for (int j = i + 1; j < nv; j++)
				if (vtx_mod[j] == mi && graph_adj[i][j])
					mod_edges[mi-1] = sat_add(mod_edges[mi-1], 32767, 1);
		end
		esum = 0;
		dsq = 0;
		for (int i = 0; i < nm; i++) begin
			esum += mod_edges[i];
			dsq += longint'(mod_deg[i]) * mod_deg[i];
		end
		m = edge_cnt;
		den = 4 * m * m;
		pos = 4 * m * esum;
		neg = dsq > pos;
		mag = neg ? dsq - pos : pos - dsq;
		quo = mag / den;
		rem = mag % den;
		if (quo >= 2)
			return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
		frac = ((rem << 30) + den / 2) / den;
		val = (quo << 30) + frac;
		if (neg)
			return (val >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-val);
		return (val > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(val);
	endfunction

	// Apply one accepted command to the shadow state.
	function automatic void apply_command(opcode_t op, int unsigned a, int unsigned b,
			int unsigned mod_num);
		q_result_t r;
		case (op)
			OP_ADD_EDGE: begin
				if (a != b && !graph_adj[a][b]) begin
					graph_adj[a][b] = 1'b1;
					graph_adj[b][a] = 1'b1;
					deg[a] = sat_add(deg[a], 255, 1);
					deg[b] = sat_add(deg[b], 255, 1);
					edge_cnt = sat_add(edge_cnt, 32767, 1);
				end
			end
			OP_ASSIGN: vtx_mod[a] = mod_num;
			OP_COMPUTE: begin
				r.empty = (edge_cnt == 0);
				r.q = r.empty ? '0 : modularity_of_graph();
				q_pending.push_back(r);
			end
			default: clear_graph();
		endcase
	endfunction

	// Send one command transaction, with random idle cycles before it.
	task automatic send_item(opcode_t op, int unsigned a, int unsigned b, int unsigned mod_num);
		@(negedge clk);
		while ($urandom_range(99, 0) < src_idle_pct) begin
			item_ch.valid = 1'b0;
			@(negedge clk);
		end
		item_ch.valid = 1'b1;
		item_ch.opcode = op;
		item_ch.vertex_a = a[VTX_W-1:0];
		item_ch.vertex_b = b[VTX_W-1:0];
		item_ch.module_number = mod_num[MOD_W-1:0];
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		apply_command(op, a, b, mod_num);
	endtask

	// Drop valid and wait until the block has nothing left to deliver.
	task automatic drain();
		@(negedge clk);
		item_ch.valid = 1'b0;
		while (q_pending.size() != 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, int unsigned value);
		drain();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = value[CFG_W-1:0];
		if (idx == CFG_VERTEX_COUNT)
			vc_reg = value & 9'h1FF;
		else
			mc_reg = value & 9'h1FF;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic report_mismatch(string what, longint expv, longint gotv);
		$display("MISMATCH %s: expected %0d, got %0d at %0t", what, expv, gotv, $realtime);
		err_count++;
	endtask

	// Receiver stalls at random.
	always @(negedge clk)
		res_ch.ready <= ($urandom_range(99, 0) >= snk_stall_pct);

	// Compare each result transaction with the oldest expectation.
	always @(posedge clk) begin
		q_result_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (q_pending.size() == 0) begin
				report_mismatch("unexpected result", 0, res_ch.modularity);
			end else begin
				e = q_pending.pop_front();
				if (res_ch.modularity !== e.q)
					report_mismatch("modularity", e.q, res_ch.modularity);
				if (res_ch.no_edges !== e.empty)
					report_mismatch("no_edges", e.empty, res_ch.no_edges);
			end
		end
	end

	// Extremes of every field, duplicates, self-loops and the empty graph.
	task automatic test_directed();
		send_item(OP_COMPUTE, 0, 0, 0);
		send_item(OP_ADD_EDGE, 7, 7, 0);
		send_item(OP_COMPUTE, 255, 255, 511);
		send_item(OP_ADD_EDGE, 0, 255, 0);
		send_item(OP_ADD_EDGE, 255, 0, 0);
		send_item(OP_ADD_EDGE, 0, 255, 511);
		send_item(OP_ADD_EDGE, 1, 2, 0);
		send_item(OP_ADD_EDGE, 2, 3, 0);
		send_item(OP_ADD_EDGE, 3, 1, 0);
		send_item(OP_ADD_EDGE, 4, 5, 0);
		send_item(OP_COMPUTE, 0, 0, 0);
		send_item(OP_ASSIGN, 0, 0, 256);
		send_item(OP_ASSIGN, 255, 0, 256);
		send_item(OP_ASSIGN, 1, 255, 1);
		send_item(OP_ASSIGN, 2, 0, 1);
		send_item(OP_ASSIGN, 3, 0, 1);
		send_item(OP_ASSIGN, 4, 0, 2);
		send_item(OP_ASSIGN, 5, 0, 511);
		send_item(OP_COMPUTE, 0, 0, 0);
		send_item(OP_ASSIGN, 5, 0, 2);
		send_item(OP_COMPUTE, 0, 0, 0);
		send_item(OP_CLEAR, 255, 255, 511);
		send_item(OP_COMPUTE, 0, 0, 0);
	endtask

	// A star on vertex 0 drives its degree to the top of its range.
	task automatic test_star();
		send_item(OP_CLEAR, 0, 0, 0);
		for (int b = 1; b < NV; b++)
			send_item(OP_ADD_EDGE, 0, b, 0);
		send_item(OP_ADD_EDGE, 9, 0, 0);
		for (int v = 0; v < 8; v++)
			send_item(OP_ASSIGN, v, 0, 1 + v % 2);
		send_item(OP_ASSIGN, 255, 0, 1);
		send_item(OP_COMPUTE, 0, 0, 0);
		send_item(OP_CLEAR, 0, 0, 0);
	endtask

	// Mostly well-formed graph builds ending in a compute, with some noise.
	task automatic test_random(int unsigned n_items, int unsigned vspan, int unsigned mspan);
		int unsigned sel;
		for (int n = 0; n < n_items; n++) begin
			sel = $urandom_range(99, 0);
			if (sel < 60) begin
				if ($urandom_range(9, 0) == 0)
					send_item(OP_ADD_EDGE, $urandom_range(255, 0), $urandom_range(255, 0),
						$urandom_range(511, 0));
				else
					send_item(OP_ADD_EDGE, $urandom_range(vspan, 0), $urandom_range(vspan, 0),
						$urandom_range(511, 0));
			end else if (sel < 88) begin
				if ($urandom_range(9, 0) == 0)
					send_item(OP_ASSIGN, $urandom_range(255, 0), $urandom_range(255, 0),
						$urandom_range(511, 0));
				else
					send_item(OP_ASSIGN, $urandom_range(vspan, 0), $urandom_range(255, 0),
						$urandom_range(mspan, 0));
			end else if (sel < 97) begin
				send_item(OP_COMPUTE, $urandom_range(255, 0), $urandom_range(255, 0),
					$urandom_range(511, 0));
			end else begin
				send_item(OP_CLEAR, $urandom_range(255, 0), $urandom_range(255, 0),
					$urandom_range(511, 0));
			end
		end
	endtask

	// Random traffic over several register settings and idling phases.
	task automatic test_settings();
		write_reg(CFG_VERTEX_COUNT, 16);
		write_reg(CFG_MODULE_COUNT, 4);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		test_random(150, 17, 5);
		write_reg(CFG_VERTEX_COUNT, 24);
		write_reg(CFG_MODULE_COUNT, 511);
		src_idle_pct = 55;
		test_random(110, 23, 8);
		write_reg(CFG_VERTEX_COUNT, 0);
		write_reg(CFG_MODULE_COUNT, 0);
		src_idle_pct = 0;
		snk_stall_pct = 55;
		test_random(80, 15, 3);
		write_reg(CFG_VERTEX_COUNT, 1);
		write_reg(CFG_MODULE_COUNT, 1);
		test_random(50, 7, 2);
		write_reg(CFG_VERTEX_COUNT, 40);
		write_reg(CFG_MODULE_COUNT, 256);
		src_idle_pct = 14;
		snk_stall_pct = 14;
		test_random(120, 47, 300);
		write_reg(CFG_VERTEX_COUNT, 511);
		write_reg(CFG_MODULE_COUNT, 511);
		src_idle_pct = 0;
		snk_stall_pct = 0;
		send_item(OP_CLEAR, 0, 0, 0);
		test_random(100, 255, 511);
		write_reg(CFG_VERTEX_COUNT, 256);
		write_reg(CFG_MODULE_COUNT, 256);
	endtask

	// Sequence of tests.
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_VERTEX_COUNT;
		cfg_data = '0;
		item_ch.valid = 1'b0;
		item_ch.opcode = OP_ADD_EDGE;
		item_ch.vertex_a = '0;
		item_ch.vertex_b = '0;
		item_ch.module_number = '0;
		res_ch.ready = 1'b0;
		err_count = 0;
		src_idle_pct = 0;
		snk_stall_pct = 0;
		vc_reg = VC_RESET;
		mc_reg = MC_RESET;
		clear_graph();
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (400) @(posedge clk);
		test_directed();
		test_star();
		test_settings();
		drain();
		if (err_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// Run limit.
	initial begin
		#6000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
`default_nettype wire

// ===== filelist.f =====
rtl/gpm_pkg.sv
rtl/gpm_if.sv
rtl/gpm_ram.sv
rtl/graph_partition_modularity_unit.sv
verif/tb_top.sv
